>>> sv/ekdd_pkg.sv
// Shared types, constants and helpers for the kickstart duty driver.
`timescale 1ns / 1ps
`default_nettype none
package ekdd_pkg;

  localparam int unsigned MOTORS_DEF  = 12;
  localparam int unsigned MAP_NIBBLES = 12;

  localparam logic [15:0] FULL_Q15   = 16'd32768;
  localparam logic [11:0] DUTY_MAX   = 12'd4095;
  localparam logic [6:0]  REG_BASE   = 7'd6;

  localparam logic [15:0] ON_THRESHOLD_RST  = 16'd32;
  localparam logic [11:0] SPIN_FLOOR_RST    = 12'd512;
  localparam logic [3:0]  KICK_FRAMES_RST   = 4'd1;
  localparam logic [47:0] CHANNEL_MAP_RST   = 48'hDCBA98543210;

  typedef enum logic {
    OP_UPDATE  = 1'b0,
    OP_ALL_OFF = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_ON_THRESHOLD  = 2'd0,
    REG_SPIN_FLOOR    = 2'd1,
    REG_KICK_FRAMES   = 2'd2,
    REG_CHANNEL_MAP   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  motor;
    logic [15:0] intensity;
  } in_t;

  typedef struct packed {
    logic [3:0]  channel;
    logic [6:0]  register_addr;
    logic [11:0] duty;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] on_threshold;
    logic [11:0] spin_floor;
    logic [3:0]  kick_frames;
    logic [47:0] channel_map;
  } cfg_t;

  // one memory entry per motor
  typedef struct packed {
    logic [11:0] duty;
    logic [3:0]  kick;
  } state_t;

  // motors past the map read channel 0
  function automatic logic [3:0] chan_of(logic [47:0] map, logic [3:0] m);
    logic [3:0] ch;
    ch = 4'd0;
    for (int i = 0; i < MAP_NIBBLES; i++) begin
      if (m == 4'(i)) begin
        ch = map[4*i +: 4];
      end
    end
    return ch;
  endfunction

  function automatic logic [6:0] reg_addr(logic [3:0] ch);
    return REG_BASE + {1'b0, ch, 2'b00};
  endfunction

endpackage
`default_nettype wire

>>> sv/ekdd_cfg_regs.sv
// Configuration register file of the kickstart duty driver.
`timescale 1ns / 1ps
`default_nettype none
module ekdd_cfg_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire ekdd_pkg::cfg_reg_e cfg_idx_i,
  input  wire logic [47:0]       cfg_wdata_i,
  output ekdd_pkg::cfg_t         cfg_o
);
  import ekdd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ON_THRESHOLD:  cfg_d.on_threshold  = cfg_wdata_i[15:0];
        REG_SPIN_FLOOR:    cfg_d.spin_floor    = cfg_wdata_i[11:0];
        REG_KICK_FRAMES:   cfg_d.kick_frames   = cfg_wdata_i[3:0];
        REG_CHANNEL_MAP:   cfg_d.channel_map   = cfg_wdata_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_threshold  <= ON_THRESHOLD_RST;
      cfg_q.spin_floor    <= SPIN_FLOOR_RST;
      cfg_q.kick_frames   <= KICK_FRAMES_RST;
      cfg_q.channel_map   <= CHANNEL_MAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> sv/ekdd_state_mem.sv
// Per-motor state memory with valid bits, bulk clear and write forwarding.
`timescale 1ns / 1ps
`default_nettype none
module ekdd_state_mem #(
  parameter int unsigned MOTORS = ekdd_pkg::MOTORS_DEF,
  parameter int unsigned AW     = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [AW-1:0]    rd_addr_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire ekdd_pkg::state_t wr_data_i,
  input  wire logic             clear_i,
  output ekdd_pkg::state_t      rd_data_o
);
  import ekdd_pkg::*;

  state_t              mem [MOTORS];
  state_t              ram_q;
  logic [AW-1:0]       rd_addr_q;
  logic [MOTORS-1:0]   vld_q, vld_d;
  logic                fwd_q;
  logic [AW-1:0]       fwd_addr_q;
  state_t              fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    ram_q      <= mem[rd_addr_i];
    rd_addr_q  <= rd_addr_i;
    fwd_addr_q <= wr_addr_i;
    fwd_data_q <= wr_data_i;
  end

  always_comb begin
    vld_d = vld_q;
    if (clear_i) begin
      vld_d = '0;
    end else if (wr_en_i) begin
      vld_d[wr_addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      fwd_q <= wr_en_i && !clear_i;
    end
  end

  // the read raced a write to the same entry on the last edge: take the new word
  always_comb begin
    if (fwd_q && (fwd_addr_q == rd_addr_q)) begin
      rd_data_o = fwd_data_q;
    end else if (vld_q[rd_addr_q]) begin
      rd_data_o = ram_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule
`default_nettype wire

>>> sv/erm_kickstart_duty_driver_top.sv
// Top level of the vibration motor duty driver with overdrive kickstart.
`timescale 1ns / 1ps
`default_nettype none
// An update word is accepted every cycle while the output is not stalled, the
// next one while the previous result still waits in the output register; its
// PWM write (if the duty changes) goes to the output register. Motor state lives
// in a one-port-read, one-port-write memory read in the accept cycle and written
// back as the word leaves the update stage, with forwarding between back-to-back
// words to the same motor. An all_off word emits MOTORS writes, one per cycle
// while the output is not stalled, and stalls the input until its last write is
// loaded. No clearing pass after reset: valid bits serve.
module erm_kickstart_duty_driver_top #(
  parameter int unsigned MOTORS = ekdd_pkg::MOTORS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire ekdd_pkg::cfg_reg_e cfg_idx_i,
  input  wire logic [47:0]       cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ekdd_pkg::in_t     in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ekdd_pkg::out_t         out_word_o
);
  import ekdd_pkg::*;

  localparam int unsigned AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  cfg_t   cfg;
  state_t cur, nxt;

  logic          in_accept, in_keep;
  logic [27:0]   prod;
  logic [15:0]   sat;
  logic [AW-1:0] rd_addr;

  logic          s1_valid_q, s1_valid_d;
  op_e           s1_op_q;
  logic [AW-1:0] s1_addr_q;
  logic          s1_on_q;
  logic [11:0]   s1_nom_q;
  logic [AW-1:0] cnt_q, cnt_d;

  logic          out_free, emit, s1_finish, wr_en, clear, out_load;
  logic [3:0]    kick_ld, ch;
  out_t          out_q, out_d;
  logic          out_valid_q, out_valid_d;

  ekdd_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  ekdd_state_mem #(.MOTORS(MOTORS), .AW(AW)) u_mem (
    .clk_i,
    .rst_ni,
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (nxt),
    .clear_i   (clear),
    .rd_data_o (cur)
  );

  // ---- accept stage: saturate, scale, threshold
  assign in_accept = in_valid_i && !in_stall_o;
  assign in_keep   = (in_word_i.op == OP_ALL_OFF) || ({1'b0, in_word_i.motor} < 5'(MOTORS));
  assign sat       = (in_word_i.intensity > FULL_Q15) ? FULL_Q15 : in_word_i.intensity;
  assign prod      = {sat, 12'd0} - {12'd0, sat};
  // reread the held word's entry while it waits
  assign rd_addr   = in_accept ? in_word_i.motor[AW-1:0] : s1_addr_q;

  // ---- update stage
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    nxt     = '0;
    kick_ld = (cur.duty == 12'd0) ? cfg.kick_frames : cur.kick;
    if (s1_on_q) begin
      if (kick_ld != 4'd0) begin
        nxt.duty = DUTY_MAX;
        nxt.kick = kick_ld - 4'd1;
      end else begin
        nxt.duty = (s1_nom_q < cfg.spin_floor) ? cfg.spin_floor : s1_nom_q;
        nxt.kick = 4'd0;
      end
    end
  end

  assign emit = (nxt.duty != cur.duty);
  assign ch   = (s1_op_q == OP_ALL_OFF) ? chan_of(cfg.channel_map, 4'(cnt_q))
                                        : chan_of(cfg.channel_map, 4'(s1_addr_q));

  always_comb begin
    s1_finish = 1'b0;
    out_load  = 1'b0;
    wr_en     = 1'b0;
    clear     = 1'b0;
    cnt_d     = cnt_q;
    out_d     = out_q;
    if (s1_valid_q) begin
      unique case (s1_op_q)
        OP_ALL_OFF: begin
          if (out_free) begin
            out_load     = 1'b1;
            out_d.duty   = 12'd0;
            out_d.last   = (cnt_q == AW'(MOTORS - 1));
            cnt_d        = cnt_q + AW'(1);
            if (cnt_q == AW'(MOTORS - 1)) begin
              s1_finish = 1'b1;
              clear     = 1'b1;
              cnt_d     = '0;
            end
          end
        end
        OP_UPDATE: begin
          if (!emit || out_free) begin
            s1_finish  = 1'b1;
            wr_en      = 1'b1;
            out_load   = emit;
            out_d.duty = nxt.duty;
            out_d.last = 1'b1;
          end
        end
        default: ;
      endcase
    end
    out_d.channel       = ch;
    out_d.register_addr = reg_addr(ch);
  end

  assign in_stall_o = s1_valid_q && !s1_finish;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = in_keep;
    end else if (s1_finish) begin
      s1_valid_d = 1'b0;
    end
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q   <= in_word_i.op;
      s1_addr_q <= in_word_i.motor[AW-1:0];
      s1_on_q   <= (sat > cfg.on_threshold);
      s1_nom_q  <= prod[26:15];
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire

>>> tb/tb_erm_kickstart_duty_driver_top.sv
// Self-checking testbench for the vibration motor kickstart duty driver top level.
`timescale 1ns / 1ps
module tb_erm_kickstart_duty_driver_top;
  import ekdd_pkg::*;

  localparam int unsigned N_MOTORS = MOTORS_DEF;

  // Tracks per-motor duty and kick state and holds the PWM writes still due.
  class duty_scoreboard;
    logic [15:0] on_thr;
    logic [11:0] min_spin;
    logic [3:0]  kick_len;
    logic [47:0] chan_map;
    logic [11:0] duty_mem [N_MOTORS];
    logic [3:0]  kick_mem [N_MOTORS];
    out_t        writes_due [$];
    int          errors;

    function new();
      on_thr   = ON_THRESHOLD_RST;
      min_spin = SPIN_FLOOR_RST;
      kick_len = KICK_FRAMES_RST;
      chan_map = CHANNEL_MAP_RST;
      for (int m = 0; m < N_MOTORS; m++) begin
        duty_mem[m] = '0;
        kick_mem[m] = '0;
      end
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [47:0] data);
      case (idx)
        REG_ON_THRESHOLD:  on_thr   = data[15:0];
        REG_SPIN_FLOOR:    min_spin = data[11:0];
        REG_KICK_FRAMES:   kick_len = data[3:0];
        REG_CHANNEL_MAP:   chan_map = data;
        default: ;
      endcase
    endfunction

    function out_t pwm_write(int m, logic [11:0] duty, logic last);
      out_t wr;
      wr.channel       = (m < 12) ? chan_map[4*m +: 4] : 4'd0;
      wr.register_addr = REG_BASE + 7'(4 * wr.channel);
      wr.duty          = duty;
      wr.last          = last;
      return wr;
    endfunction

    // Predict the writes caused by one accepted input word.
    function void note_word(in_t w);
      int unsigned lvl;
      logic [11:0] duty;
      int          m;
      if (w.op == OP_ALL_OFF) begin
        for (int k = 0; k < N_MOTORS; k++) begin
          writes_due.push_back(pwm_write(k, 12'd0, k == N_MOTORS - 1));
          duty_mem[k] = '0;
          kick_mem[k] = '0;
        end
        return;
      end
      if (w.motor >= N_MOTORS) return;
      m   = int'(w.motor);
      lvl = w.intensity;
      if (lvl > FULL_Q15) lvl = FULL_Q15;
      if (lvl > on_thr) begin
        duty = 12'((lvl * 4095) >> 15);
        if (duty_mem[m] == 12'd0) kick_mem[m] = kick_len;
        if (kick_mem[m] != 4'd0) begin
          duty        = DUTY_MAX;
          kick_mem[m] = kick_mem[m] - 4'd1;
        end else if (duty < min_spin) begin
          duty = min_spin;
        end
      end else begin
        duty        = '0;
        kick_mem[m] = '0;
      end
      if (duty != duty_mem[m]) begin
        writes_due.push_back(pwm_write(m, duty, 1'b1));
        duty_mem[m] = duty;
      end
    endfunction

    function void check_write(out_t got);
      out_t exp_wr;
      if (writes_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected write: ch %0d addr %0d duty %0d last %0b",
                   got.channel, got.register_addr, got.duty, got.last);
        return;
      end
      exp_wr = writes_due.pop_front();
      if (got.channel != exp_wr.channel || got.register_addr != exp_wr.register_addr ||
          got.duty != exp_wr.duty || got.last != exp_wr.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp ch %0d addr %0d duty %0d last %0b, got ch %0d addr %0d duty %0d last %0b",
                   exp_wr.channel, exp_wr.register_addr, exp_wr.duty, exp_wr.last,
                   got.channel, got.register_addr, got.duty, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_reg_e    cfg_idx = REG_ON_THRESHOLD;
  logic [47:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_word;

  int send_idle_pct = 0;
  int stall_pct = 0;

  duty_scoreboard sb = new();

  erm_kickstart_duty_driver_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_word(in_word);
    if (rst_n && out_valid && !out_stall) sb.check_write(out_word);
  end

  task automatic send_word(input in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, drain every pending write, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.writes_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_regs(input logic [47:0] thr, mins, kick, map);
    logic [47:0] vals [4];
    cfg_reg_e    idx;
    vals = '{thr, mins, kick, map};
    for (int i = 0; i < 4; i++) begin
      idx = cfg_reg_e'(i);
      cfg_we    <= 1'b1;
      cfg_idx   <= idx;
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(idx, vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count);
    in_t w;
    int  pick;
    int  n;
    n = 0;
    while (n < count) begin
      pick        = $urandom_range(99);
      w.op        = OP_UPDATE;
      w.motor     = 4'($urandom_range(15));
      if (pick < 6) w.op = OP_ALL_OFF;
      else if (pick < 14) w.motor = 4'($urandom_range(15, N_MOTORS));
      else if (pick < 60) w.motor = 4'($urandom_range(2));   // hot motors: long sequences
      else w.motor = 4'($urandom_range(N_MOTORS - 1));
      case ($urandom_range(7))
        0: w.intensity = 16'd0;
        1: w.intensity = sb.on_thr;
        2: w.intensity = sb.on_thr + 16'd1;
        3: w.intensity = FULL_Q15;
        4: w.intensity = 16'($urandom_range(65535));
        5: w.intensity = 16'($urandom_range(65535, 32769));
        default: w.intensity = 16'($urandom_range(32768));
      endcase
      send_word(w);
      if (w.op == OP_ALL_OFF || w.motor < N_MOTORS) n++;
    end
  endtask

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: kick, clamp, saturation, ignored motors, all off
    send_word(in_t'{OP_UPDATE, 4'd0, 16'd0});
    send_word(in_t'{OP_UPDATE, 4'd0, 16'd32});
    send_word(in_t'{OP_UPDATE, 4'd0, 16'd33});
    send_word(in_t'{OP_UPDATE, 4'd0, 16'd33});
    send_word(in_t'{OP_UPDATE, 4'd0, 16'd33});
    send_word(in_t'{OP_UPDATE, 4'd0, 16'd32768});
    send_word(in_t'{OP_UPDATE, 4'd0, 16'd65535});
    send_word(in_t'{OP_UPDATE, 4'd1, 16'd65535});
    send_word(in_t'{OP_UPDATE, 4'd1, 16'd16384});
    send_word(in_t'{OP_UPDATE, 4'd11, 16'd1000});
    send_word(in_t'{OP_UPDATE, 4'd12, 16'd30000});
    send_word(in_t'{OP_UPDATE, 4'd15, 16'hFFFF});
    send_word(in_t'{OP_ALL_OFF, 4'd7, 16'd0});
    send_word(in_t'{OP_ALL_OFF, 4'd15, 16'hFFFF});
    send_word(in_t'{OP_UPDATE, 4'd5, 16'd32768});
    send_word(in_t'{OP_UPDATE, 4'd5, 16'd0});
    send_word(in_t'{OP_UPDATE, 4'd5, 16'd0});
    send_word(in_t'{OP_UPDATE, 4'd2, 16'd50000});
    send_word(in_t'{OP_UPDATE, 4'd2, 16'd20000});
    send_word(in_t'{OP_UPDATE, 4'd10, 16'h5555});
    send_word(in_t'{OP_UPDATE, 4'd10, 16'h2AAA});
    send_word(in_t'{OP_UPDATE, 4'd10, 16'h2AAA});
    settle();

    program_regs(48'd0, 48'd4095, 48'd0, 48'hFFFF_FFFF_FFFF);
    run_random(40);
    settle();

    send_idle_pct = 81;
    program_regs(48'd32767, 48'd0, 48'd15, 48'd0);
    run_random(40);
    settle();

    // upper data bits must be dropped
    send_idle_pct = 0;
    stall_pct     = 81;
    program_regs(48'hABCD_1234_0100, 48'h5A5A_5000_0080, 48'h0000_0000_00F3,
                 48'({$urandom, $urandom}));
    run_random(40);
    settle();

    send_idle_pct = 31;
    stall_pct     = 31;
    program_regs(48'($urandom_range(2000)), 48'($urandom_range(4095)),
                 48'($urandom_range(15)), 48'({$urandom, $urandom}));
    run_random(40);
    settle();

    send_idle_pct = 0;
    stall_pct     = 0;
    program_regs(48'd32768, 48'd4095, 48'd15, CHANNEL_MAP_RST);
    run_random(20);
    settle();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ekdd_pkg.sv
sv/ekdd_cfg_regs.sv
sv/ekdd_state_mem.sv
sv/erm_kickstart_duty_driver_top.sv
tb/tb_erm_kickstart_duty_driver_top.sv
